// File: design/fbik_pkg.sv
// shared types, widths and constants for the five-bar inverse kinematics unit
// no dependencies
`timescale 1ns / 1ps

package fbik_pkg;

    localparam int COORD_W  = 16;   // signed q7.8 coordinate
    localparam int ANGLE_W  = 16;   // signed q3.12 angle
    localparam int LEN_W    = 15;   // unsigned q7.8 length
    localparam int MUL_W    = 17;   // shared multiplier operand width
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SQ_IN_W  = 34;   // isqrt radicand width
    localparam int ROOT_W   = SQ_IN_W / 2;
    localparam int MAG_W    = 35;   // cosine rule numerator
    localparam int DEN_W    = 33;   // cosine rule denominator
    localparam int COS_W    = 15;   // cosine magnitude, q1.14
    localparam int CORDIC_N = 20;
    localparam int CORDIC_W = 34;
    localparam int Z_W      = 24;   // angle accumulator, q.20
    localparam int ADDR_W   = 3;

    localparam logic signed [Z_W-1:0] PI_Q20 = 24'sd3294199;
    localparam logic [COS_W-1:0] ONE_Q14 = 15'd16384;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_SOLVED = 2'd0;
    localparam status_t STATUS_RANGE  = 2'd1;
    localparam status_t STATUS_HOLD   = 2'd2;

    localparam logic [ADDR_W-1:0] REG_BASE     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_LEFT_PX  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_LEFT_DS  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_RIGHT_DS = 3'd3;
    localparam logic [ADDR_W-1:0] REG_RIGHT_PX = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL, ST_SUM, ST_CHECK,
        ST_ATAN_GO, ST_ATAN_WAIT, ST_SQRT_GO, ST_SQRT_WAIT,
        ST_DEN, ST_MAG, ST_DIV_GO, ST_DIV_WAIT, ST_CSQ,
        ST_S2_GO, ST_S2_WAIT, ST_ACOS_GO, ST_ACOS_WAIT,
        ST_FIN, ST_DIFF, ST_PICK, ST_LOAD
    } state_t;

    // arctangent of 2^-i in q.20
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 24'sd823550;
                5'd1:    v = 24'sd486170;
                5'd2:    v = 24'sd256879;
                5'd3:    v = 24'sd130396;
                5'd4:    v = 24'sd65451;
                5'd5:    v = 24'sd32757;
                5'd6:    v = 24'sd16383;
                5'd7:    v = 24'sd8192;
                5'd8:    v = 24'sd4096;
                5'd9:    v = 24'sd2048;
                5'd10:   v = 24'sd1024;
                5'd11:   v = 24'sd512;
                5'd12:   v = 24'sd256;
                5'd13:   v = 24'sd128;
                5'd14:   v = 24'sd64;
                5'd15:   v = 24'sd32;
                5'd16:   v = 24'sd16;
                5'd17:   v = 24'sd8;
                5'd18:   v = 24'sd4;
                5'd19:   v = 24'sd2;
                default: v = 24'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: design/fbik_isqrt.sv
// iterative floor square root, two radicand bits per cycle
// depends on fbik_pkg
`timescale 1ns / 1ps

module fbik_isqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [fbik_pkg::SQ_IN_W-1:0]      radicand,
    output logic                              done,
    output logic [fbik_pkg::ROOT_W-1:0]       root
);

    localparam int REM_W = fbik_pkg::ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic [fbik_pkg::SQ_IN_W-1:0] val_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [fbik_pkg::ROOT_W-1:0]  root_reg;
    logic [4:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    logic [SH_W-1:0] diff;
    logic            ge;

    assign rem_sh = {rem_reg, val_reg[fbik_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= 5'(fbik_pkg::ROOT_W);
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[fbik_pkg::SQ_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[fbik_pkg::ROOT_W-2:0], ge};
            cnt_reg  <= cnt_reg - 5'd1;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: design/fbik_div.sv
// restoring divider for the rounded cosine, one quotient bit per cycle
// depends on fbik_pkg
`timescale 1ns / 1ps

module fbik_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [fbik_pkg::MAG_W-1:0]      mag,
    input  logic [fbik_pkg::DEN_W-1:0]      den,
    output logic                            done,
    output logic [fbik_pkg::COS_W-1:0]      quo
);

    localparam int Q_W   = fbik_pkg::COS_W;
    localparam int NUM_W = fbik_pkg::MAG_W + Q_W - 1;
    localparam int REM_W = fbik_pkg::DEN_W + 1;

    logic [NUM_W-1:0]            num;
    logic [REM_W-1:0]            rem_reg;
    logic [Q_W-1:0]              low_reg;
    logic [Q_W-1:0]              quo_reg;
    logic [fbik_pkg::DEN_W-1:0]  den_reg;
    logic [3:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [REM_W:0] rem_sh;
    logic [REM_W:0] diff;
    logic           ge;

    // numerator mag * 2^14 plus half the divisor for rounding
    assign num    = {mag, {(Q_W-1){1'b0}}} + NUM_W'(den >> 1);
    assign rem_sh = {rem_reg, low_reg[Q_W-1]};
    assign ge     = rem_sh >= (REM_W+1)'(den_reg);
    assign diff   = rem_sh - (REM_W+1)'(den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == 4'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:Q_W];
            low_reg <= num[Q_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
            cnt_reg <= 4'(Q_W);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[Q_W-2:0], ge};
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: design/fbik_cordic.sv
// vectoring cordic atan2, one micro-rotation per cycle
// depends on fbik_pkg
`timescale 1ns / 1ps

module fbik_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [fbik_pkg::MUL_W-1:0] yin,
    input  logic signed [fbik_pkg::MUL_W-1:0] xin,
    output logic                              done,
    output logic signed [fbik_pkg::Z_W-1:0]   angle
);

    localparam int W = fbik_pkg::CORDIC_W;

    logic signed [W-1:0]              x_reg;
    logic signed [W-1:0]              y_reg;
    logic signed [fbik_pkg::Z_W-1:0]  z_reg;
    logic [4:0]                       i_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic signed [W-1:0] x_in;
    logic signed [W-1:0] y_in;
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic                is_zero;
    logic                x_neg;

    assign x_in    = W'(xin);
    assign y_in    = W'(yin);
    assign is_zero = (xin == '0) && (yin == '0);
    assign x_neg   = xin[fbik_pkg::MUL_W-1];
    assign xs      = x_reg >>> i_reg;
    assign ys      = y_reg >>> i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !is_zero;
                done_reg <= is_zero;
            end
            else if (busy_reg && i_reg == 5'(fbik_pkg::CORDIC_N - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg <= '0;
            if (is_zero)
            begin
                z_reg <= '0;
            end
            else if (x_neg)
            begin
                // left half plane: rotate by pi first
                x_reg <= (-x_in) <<< 12;
                y_reg <= (-y_in) <<< 12;
                z_reg <= yin[fbik_pkg::MUL_W-1] ? -fbik_pkg::PI_Q20 : fbik_pkg::PI_Q20;
            end
            else
            begin
                x_reg <= x_in <<< 12;
                y_reg <= y_in <<< 12;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            i_reg <= i_reg + 5'd1;
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + fbik_pkg::atan_q20(i_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - fbik_pkg::atan_q20(i_reg);
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

// File: design/five_bar_inverse_kinematics_unit.sv
// five-bar inverse kinematics: one target point in, one angle result out
// for a point in reach each arm takes up to two cordic runs, two square roots and a divide before
// the result is loaded; a point out of reach goes from the range check straight to the output
// one point at a time: s_axis_tready is high only while idle; a finished result waits in the
// output register, so the next point can be taken before that result is transferred
// rst_n clears the sequencer, the previous angles and the config registers to their defaults
// depends on fbik_pkg, fbik_isqrt, fbik_div, fbik_cordic
`timescale 1ns / 1ps

module five_bar_inverse_kinematics_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_we,
    input  logic [fbik_pkg::ADDR_W-1:0]        cfg_addr,
    input  logic [fbik_pkg::LEN_W-1:0]         cfg_wdata,
    // target point stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,  // target_x, target_y
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // first_angle, second_angle, first_plus, first_minus, second_plus, second_minus
    output logic [95:0]                        m_axis_tdata,
    output logic [1:0]                         m_axis_tuser   // status
);

    localparam int CW = fbik_pkg::COORD_W;
    localparam int AW = fbik_pkg::ANGLE_W;
    localparam int LW = fbik_pkg::LEN_W;
    localparam int MW = fbik_pkg::MUL_W;
    localparam int PW = fbik_pkg::PROD_W;
    localparam int ZW = fbik_pkg::Z_W;

    // multiplier schedule for the setup pass
    localparam logic [3:0] MS_XX   = 4'd0;
    localparam logic [3:0] MS_YY   = 4'd1;
    localparam logic [3:0] MS_DD   = 4'd2;
    localparam logic [3:0] MS_HI1  = 4'd3;
    localparam logic [3:0] MS_LO1  = 4'd4;
    localparam logic [3:0] MS_HI2  = 4'd5;
    localparam logic [3:0] MS_LO2  = 4'd6;
    localparam logic [3:0] MS_LP1  = 4'd7;
    localparam logic [3:0] MS_LD1  = 4'd8;
    localparam logic [3:0] MS_LP2  = 4'd9;
    localparam logic [3:0] MS_LD2  = 4'd10;

    fbik_pkg::state_t state_reg, state_next;

    // config registers
    logic [LW-1:0] base_reg, lp1_reg, ld1_reg, ld2_reg, lp2_reg;

    // kept angles
    logic signed [AW-1:0] last1_reg, last2_reg;
    logic                 have_last_reg;

    // working registers
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [MW-1:0] dx_reg;
    logic [3:0]           k_reg;
    logic                 arm_reg;
    logic                 hold_reg;
    logic [PW-1:0]        sx_reg, sy_reg, sdx_reg;
    logic [PW-1:0]        hi1_reg, lo1_reg, hi2_reg, lo2_reg;
    logic [PW-1:0]        lpsq1_reg, ldsq1_reg, lpsq2_reg, ldsq2_reg;
    logic [PW-1:0]        r1_reg, r2_reg;
    logic                 reach_ok;
    logic signed [ZW-1:0] a_reg, b_reg;
    logic [fbik_pkg::ROOT_W-1:0] d_reg;
    logic [PW-1:0]        lpd_reg;
    logic [fbik_pkg::MAG_W-1:0] pos_reg, mag_reg;
    logic [fbik_pkg::DEN_W-1:0] den_reg;
    logic                 cneg_reg;
    logic [fbik_pkg::COS_W-1:0] cmag_reg;
    logic [PW-1:0]        csq_reg;
    logic [fbik_pkg::COS_W-1:0] s_reg;
    logic signed [AW-1:0] fp_reg, fm_reg, sp_reg, sm_reg, f_reg, s_ang_reg;
    logic [AW:0]          dfp_reg, dfm_reg, dsp_reg, dsm_reg;
    fbik_pkg::status_t    status_reg;

    // output register
    logic                 out_valid_reg;
    logic [95:0]          out_data_reg;
    logic [1:0]           out_user_reg;

    // shared multiplier
    logic [MW-1:0]        mul_a, mul_b;
    logic [PW-1:0]        mul_p;

    // unit handshakes
    logic                 sq_start, sq_done;
    logic [fbik_pkg::SQ_IN_W-1:0] sq_in;
    logic [fbik_pkg::ROOT_W-1:0]  sq_root;
    logic                 dv_start, dv_done;
    logic [fbik_pkg::COS_W-1:0]   dv_quo;
    logic                 co_start, co_done;
    logic signed [MW-1:0] co_y, co_x;
    logic signed [ZW-1:0] co_angle;

    // arm-dependent selections
    logic signed [MW-1:0] x_ext;
    logic signed [MW-1:0] dx_c;
    logic [MW-1:0]        ax_mag, ay_mag, adx_mag;
    logic [LW-1:0]        lp_sel;
    logic [PW-1:0]        r_sel, lpsq_sel, ldsq_sel;
    logic [LW:0]          sum1, sum2;
    logic [LW-1:0]        dif1, dif2;
    logic signed [ZW:0]   ang_plus, ang_minus;
    logic signed [MW-1:0] c_signed;
    logic                 load_ok;

    // q.20 to saturated q3.12 with round half up
    function automatic logic signed [AW-1:0] to_angle(input logic signed [ZW:0] v);
        logic signed [ZW:0]   t;
        logic signed [ZW-8:0] q;
        logic signed [ZW-8:0] hi;
        logic signed [ZW-8:0] lo;
        begin
            t  = v + (ZW+1)'(128);
            q  = (ZW-7)'(t >>> 8);
            hi = (ZW-7)'({1'b0, {(AW-1){1'b1}}});
            lo = -hi - (ZW-7)'(1);
            if (q > hi)
            begin
                q = hi;
            end
            else if (q < lo)
            begin
                q = lo;
            end
            return q[AW-1:0];
        end
    endfunction

    assign x_ext   = MW'(x_reg);
    assign dx_c    = x_ext - $signed({2'b00, base_reg});
    assign ax_mag  = x_ext[MW-1] ? MW'(-x_ext) : x_ext;
    assign ay_mag  = y_reg[CW-1] ? MW'(-MW'(y_reg)) : MW'(y_reg);
    assign adx_mag = dx_c[MW-1] ? MW'(-dx_c) : dx_c;
    assign sum1    = {1'b0, lp1_reg} + {1'b0, ld1_reg};
    assign sum2    = {1'b0, lp2_reg} + {1'b0, ld2_reg};
    assign dif1    = (lp1_reg > ld1_reg) ? lp1_reg - ld1_reg : ld1_reg - lp1_reg;
    assign dif2    = (lp2_reg > ld2_reg) ? lp2_reg - ld2_reg : ld2_reg - lp2_reg;

    assign lp_sel   = arm_reg ? lp2_reg   : lp1_reg;
    assign r_sel    = arm_reg ? r2_reg    : r1_reg;
    assign lpsq_sel = arm_reg ? lpsq2_reg : lpsq1_reg;
    assign ldsq_sel = arm_reg ? ldsq2_reg : ldsq1_reg;

    assign reach_ok = (r1_reg <= hi1_reg) && (r1_reg >= lo1_reg) &&
                      (r2_reg <= hi2_reg) && (r2_reg >= lo2_reg);

    assign ang_plus  = (ZW+1)'(a_reg) + (ZW+1)'(b_reg);
    assign ang_minus = (ZW+1)'(a_reg) - (ZW+1)'(b_reg);
    assign c_signed  = cneg_reg ? -$signed({2'b00, cmag_reg}) : $signed({2'b00, cmag_reg});

    assign mul_p   = mul_a * mul_b;
    assign load_ok = !out_valid_reg || m_axis_tready;

    fbik_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    fbik_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .mag   (mag_reg),
        .den   (den_reg),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    fbik_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (co_start),
        .yin   (co_y),
        .xin   (co_x),
        .done  (co_done),
        .angle (co_angle)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbik_pkg::ST_IDLE:
                if (s_axis_tvalid) state_next = fbik_pkg::ST_MUL;
            fbik_pkg::ST_MUL:
                if (k_reg == MS_LD2) state_next = fbik_pkg::ST_SUM;
            fbik_pkg::ST_SUM:
                state_next = fbik_pkg::ST_CHECK;
            fbik_pkg::ST_CHECK:
                state_next = reach_ok ? fbik_pkg::ST_ATAN_GO : fbik_pkg::ST_LOAD;
            fbik_pkg::ST_ATAN_GO:
                state_next = fbik_pkg::ST_ATAN_WAIT;
            fbik_pkg::ST_ATAN_WAIT:
                if (co_done) state_next = fbik_pkg::ST_SQRT_GO;
            fbik_pkg::ST_SQRT_GO:
                state_next = fbik_pkg::ST_SQRT_WAIT;
            fbik_pkg::ST_SQRT_WAIT:
                if (sq_done) state_next = fbik_pkg::ST_DEN;
            fbik_pkg::ST_DEN:
                state_next = (lp_sel == '0 || d_reg == '0) ? fbik_pkg::ST_FIN
                                                           : fbik_pkg::ST_MAG;
            fbik_pkg::ST_MAG:
                state_next = fbik_pkg::ST_DIV_GO;
            fbik_pkg::ST_DIV_GO:
                state_next = (mag_reg >= fbik_pkg::MAG_W'(den_reg)) ? fbik_pkg::ST_CSQ
                                                                     : fbik_pkg::ST_DIV_WAIT;
            fbik_pkg::ST_DIV_WAIT:
                if (dv_done) state_next = fbik_pkg::ST_CSQ;
            fbik_pkg::ST_CSQ:
                state_next = fbik_pkg::ST_S2_GO;
            fbik_pkg::ST_S2_GO:
                state_next = fbik_pkg::ST_S2_WAIT;
            fbik_pkg::ST_S2_WAIT:
                if (sq_done) state_next = fbik_pkg::ST_ACOS_GO;
            fbik_pkg::ST_ACOS_GO:
                state_next = fbik_pkg::ST_ACOS_WAIT;
            fbik_pkg::ST_ACOS_WAIT:
                if (co_done) state_next = fbik_pkg::ST_FIN;
            fbik_pkg::ST_FIN:
                state_next = arm_reg ? fbik_pkg::ST_DIFF : fbik_pkg::ST_ATAN_GO;
            fbik_pkg::ST_DIFF:
                state_next = fbik_pkg::ST_PICK;
            fbik_pkg::ST_PICK:
                state_next = fbik_pkg::ST_LOAD;
            fbik_pkg::ST_LOAD:
                if (load_ok) state_next = fbik_pkg::ST_IDLE;
            default:
                state_next = fbik_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: unit starts and operand steering
    always_comb
    begin
        s_axis_tready = (state_reg == fbik_pkg::ST_IDLE);
        sq_start      = 1'b0;
        dv_start      = 1'b0;
        co_start      = 1'b0;
        sq_in         = r_sel;
        co_y          = MW'(y_reg);
        co_x          = arm_reg ? dx_reg : x_ext;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            fbik_pkg::ST_MUL:
            begin
                case (k_reg)
                    MS_XX:   begin mul_a = ax_mag;  mul_b = ax_mag;  end
                    MS_YY:   begin mul_a = ay_mag;  mul_b = ay_mag;  end
                    MS_DD:   begin mul_a = adx_mag; mul_b = adx_mag; end
                    MS_HI1:  begin mul_a = MW'(sum1); mul_b = MW'(sum1); end
                    MS_LO1:  begin mul_a = MW'(dif1); mul_b = MW'(dif1); end
                    MS_HI2:  begin mul_a = MW'(sum2); mul_b = MW'(sum2); end
                    MS_LO2:  begin mul_a = MW'(dif2); mul_b = MW'(dif2); end
                    MS_LP1:  begin mul_a = MW'(lp1_reg); mul_b = MW'(lp1_reg); end
                    MS_LD1:  begin mul_a = MW'(ld1_reg); mul_b = MW'(ld1_reg); end
                    MS_LP2:  begin mul_a = MW'(lp2_reg); mul_b = MW'(lp2_reg); end
                    MS_LD2:  begin mul_a = MW'(ld2_reg); mul_b = MW'(ld2_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            fbik_pkg::ST_ATAN_GO:
                co_start = 1'b1;
            fbik_pkg::ST_SQRT_GO:
                sq_start = 1'b1;
            fbik_pkg::ST_DEN:
            begin
                mul_a = MW'(lp_sel);
                mul_b = d_reg;
            end
            fbik_pkg::ST_DIV_GO:
                dv_start = (mag_reg < fbik_pkg::MAG_W'(den_reg));
            fbik_pkg::ST_CSQ:
            begin
                mul_a = MW'(cmag_reg);
                mul_b = MW'(cmag_reg);
            end
            fbik_pkg::ST_S2_GO:
            begin
                // sine magnitude from 1 - c^2 in q2.28
                sq_start = 1'b1;
                sq_in    = (fbik_pkg::SQ_IN_W'(1) << 28) - csq_reg;
            end
            fbik_pkg::ST_ACOS_GO:
            begin
                co_start = 1'b1;
                co_y     = $signed({2'b00, s_reg});
                co_x     = c_signed;
            end
            default:
                s_axis_tready = (state_reg == fbik_pkg::ST_IDLE);
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbik_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            have_last_reg <= 1'b0;
            last1_reg     <= '0;
            last2_reg     <= '0;
            base_reg      <= 15'd4096;
            lp1_reg       <= 15'd1536;
            ld1_reg       <= 15'd3840;
            ld2_reg       <= 15'd3840;
            lp2_reg       <= 15'd1536;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    fbik_pkg::REG_BASE:     base_reg <= cfg_wdata;
                    fbik_pkg::REG_LEFT_PX:  lp1_reg  <= cfg_wdata;
                    fbik_pkg::REG_LEFT_DS:  ld1_reg  <= cfg_wdata;
                    fbik_pkg::REG_RIGHT_DS: ld2_reg  <= cfg_wdata;
                    fbik_pkg::REG_RIGHT_PX: lp2_reg  <= cfg_wdata;
                    default:                base_reg <= base_reg;
                endcase
            end

            if (state_reg == fbik_pkg::ST_LOAD && load_ok)
            begin
                out_valid_reg <= 1'b1;
                if (status_reg == fbik_pkg::STATUS_SOLVED)
                begin
                    last1_reg     <= f_reg;
                    last2_reg     <= s_ang_reg;
                    have_last_reg <= 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fbik_pkg::ST_IDLE:
            begin
                x_reg   <= s_axis_tdata[15:0];
                y_reg   <= s_axis_tdata[31:16];
                k_reg   <= MS_XX;
                arm_reg <= 1'b0;
            end
            fbik_pkg::ST_MUL:
            begin
                dx_reg <= dx_c;
                k_reg  <= k_reg + 4'd1;
                case (k_reg)
                    MS_XX:   sx_reg    <= mul_p;
                    MS_YY:   sy_reg    <= mul_p;
                    MS_DD:   sdx_reg   <= mul_p;
                    MS_HI1:  hi1_reg   <= mul_p;
                    MS_LO1:  lo1_reg   <= mul_p;
                    MS_HI2:  hi2_reg   <= mul_p;
                    MS_LO2:  lo2_reg   <= mul_p;
                    MS_LP1:  lpsq1_reg <= mul_p;
                    MS_LD1:  ldsq1_reg <= mul_p;
                    MS_LP2:  lpsq2_reg <= mul_p;
                    MS_LD2:  ldsq2_reg <= mul_p;
                    default: sx_reg    <= sx_reg;
                endcase
            end
            fbik_pkg::ST_SUM:
            begin
                r1_reg   <= sx_reg + sy_reg;
                r2_reg   <= sdx_reg + sy_reg;
                hold_reg <= (x_reg == '0) && (y_reg == '0);
            end
            fbik_pkg::ST_CHECK:
            begin
                // out of reach: all angles zero, state left alone
                fp_reg     <= '0;
                fm_reg     <= '0;
                sp_reg     <= '0;
                sm_reg     <= '0;
                f_reg      <= '0;
                s_ang_reg  <= '0;
                status_reg <= fbik_pkg::STATUS_RANGE;
            end
            fbik_pkg::ST_ATAN_WAIT:
                if (co_done) a_reg <= co_angle;
            fbik_pkg::ST_SQRT_WAIT:
                if (sq_done) d_reg <= sq_root;
            fbik_pkg::ST_DEN:
            begin
                b_reg   <= '0;
                lpd_reg <= mul_p;
                pos_reg <= fbik_pkg::MAG_W'(lpsq_sel) + fbik_pkg::MAG_W'(r_sel);
            end
            fbik_pkg::ST_MAG:
            begin
                den_reg  <= {lpd_reg[fbik_pkg::DEN_W-2:0], 1'b0};
                cneg_reg <= pos_reg < fbik_pkg::MAG_W'(ldsq_sel);
                mag_reg  <= (pos_reg < fbik_pkg::MAG_W'(ldsq_sel))
                          ? fbik_pkg::MAG_W'(ldsq_sel) - pos_reg
                          : pos_reg - fbik_pkg::MAG_W'(ldsq_sel);
            end
            fbik_pkg::ST_DIV_GO:
                cmag_reg <= fbik_pkg::ONE_Q14;
            fbik_pkg::ST_DIV_WAIT:
                if (dv_done) cmag_reg <= dv_quo;
            fbik_pkg::ST_CSQ:
                csq_reg <= mul_p;
            fbik_pkg::ST_S2_WAIT:
                if (sq_done) s_reg <= sq_root[fbik_pkg::COS_W-1:0];
            fbik_pkg::ST_ACOS_WAIT:
                if (co_done) b_reg <= co_angle;
            fbik_pkg::ST_FIN:
            begin
                arm_reg <= 1'b1;
                if (arm_reg)
                begin
                    sp_reg <= to_angle(ang_plus);
                    sm_reg <= to_angle(ang_minus);
                end
                else
                begin
                    fp_reg <= to_angle(ang_plus);
                    fm_reg <= to_angle(ang_minus);
                end
            end
            fbik_pkg::ST_DIFF:
            begin
                dfp_reg <= ((fp_reg - last1_reg) < 0) ? (AW+1)'(last1_reg - fp_reg)
                                                      : (AW+1)'(fp_reg - last1_reg);
                dfm_reg <= ((fm_reg - last1_reg) < 0) ? (AW+1)'(last1_reg - fm_reg)
                                                      : (AW+1)'(fm_reg - last1_reg);
                dsp_reg <= ((sp_reg - last2_reg) < 0) ? (AW+1)'(last2_reg - sp_reg)
                                                      : (AW+1)'(sp_reg - last2_reg);
                dsm_reg <= ((sm_reg - last2_reg) < 0) ? (AW+1)'(last2_reg - sm_reg)
                                                      : (AW+1)'(sm_reg - last2_reg);
            end
            fbik_pkg::ST_PICK:
            begin
                if (hold_reg)
                begin
                    // origin: report the kept angles
                    f_reg      <= last1_reg;
                    s_ang_reg  <= last2_reg;
                    status_reg <= fbik_pkg::STATUS_HOLD;
                end
                else
                begin
                    status_reg <= fbik_pkg::STATUS_SOLVED;
                    if (have_last_reg)
                    begin
                        // nearest candidate, minus on a tie
                        f_reg     <= (dfp_reg < dfm_reg) ? fp_reg : fm_reg;
                        s_ang_reg <= (dsp_reg < dsm_reg) ? sp_reg : sm_reg;
                    end
                    else
                    begin
                        f_reg     <= fp_reg;
                        s_ang_reg <= sp_reg;
                    end
                end
            end
            fbik_pkg::ST_LOAD:
            begin
                if (load_ok)
                begin
                    out_data_reg <= {sm_reg, sp_reg, fm_reg, fp_reg, s_ang_reg, f_reg};
                    out_user_reg <= status_reg;
                end
            end
            default:
                k_reg <= k_reg;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
